### design/vtcd_pkg.sv
// ----------------------------------------------------------------------------
// vtcd_pkg: shared codes and types for the vector terminal command decoder
// Control codes, command modes, result kinds and the coordinate decoders.
// ----------------------------------------------------------------------------
package vtcd_pkg;

    // Field widths of the channels
    localparam int CODE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int OUT_POS_W = 12;
    localparam int CFG_W     = 8;
    localparam int PEND_W    = 3;
    localparam int NUM_ARGS  = 4;
    localparam int LONG_W    = 11;
    localparam int SHORT_W   = 6;

    // Control codes
    localparam logic [CODE_W-1:0] C_BEL = 8'o007;
    localparam logic [CODE_W-1:0] C_BS  = 8'o010;
    localparam logic [CODE_W-1:0] C_LF  = 8'o012;
    localparam logic [CODE_W-1:0] C_FF  = 8'o014;
    localparam logic [CODE_W-1:0] C_CR  = 8'o015;
    localparam logic [CODE_W-1:0] C_FS  = 8'o034;
    localparam logic [CODE_W-1:0] C_GS  = 8'o035;
    localparam logic [CODE_W-1:0] C_RS  = 8'o036;
    localparam logic [CODE_W-1:0] C_US  = 8'o037;

    // Command modes
    localparam logic [1:0] MODE_SYMBOL = 2'd0;
    localparam logic [1:0] MODE_POINT  = 2'd1;
    localparam logic [1:0] MODE_EXT    = 2'd2;
    localparam logic [1:0] MODE_SHORT  = 2'd3;

    // Argument counts armed by each mode
    localparam logic [PEND_W-1:0] ARGS_LONG  = 3'd4;
    localparam logic [PEND_W-1:0] ARGS_SHORT = 3'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VECTOR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // Configuration register indexes
    localparam logic CFG_CHAR_ADVANCE = 1'b0;
    localparam logic CFG_LINE_STEP    = 1'b1;

    localparam logic [CFG_W-1:0] CHAR_ADVANCE_RST = 8'd13;
    localparam logic [CFG_W-1:0] LINE_STEP_RST    = 8'd28;

    // Beam home and carriage return column
    localparam int HOME_X_VAL = -485;
    localparam int HOME_Y_VAL = 450;
    localparam int CR_X_VAL   = -479;

    // Bit that marks an extended vector invisible
    localparam int INVIS_BIT = 5;

    typedef logic [CODE_W-1:0] t_byte;

    typedef struct packed {
        logic [KIND_W-1:0]           kind;
        logic [CODE_W-1:0]           glyph;
        logic signed [OUT_POS_W-1:0] from_x;
        logic signed [OUT_POS_W-1:0] from_y;
        logic signed [OUT_POS_W-1:0] to_x;
        logic signed [OUT_POS_W-1:0] to_y;
    } t_result;

    // Sign-magnitude, 10-bit magnitude: low five from bits 5:1 of the low byte
    function automatic logic signed [LONG_W-1:0] long_coord(t_byte lo_b, t_byte hi_b);
        logic [LONG_W-1:0] mag;
        mag = {1'b0, hi_b[4:0], lo_b[5:1]};
        return lo_b[0] ? -mag : mag;
    endfunction

    // Sign-magnitude, 5-bit magnitude
    function automatic logic signed [SHORT_W-1:0] short_coord(t_byte b);
        logic [SHORT_W-1:0] mag;
        mag = {1'b0, b[5:1]};
        return b[0] ? -mag : mag;
    endfunction

endpackage

### design/vector_terminal_command_decoder.sv
// A byte is held in the input register; its result is held in the output register.
// One byte per cycle unless the output stalls; the beam add and clamp are combinational.
// The input register drains whenever the output register is empty or being taken.
// Reset (synchronous, active low) clears both stages, homes the beam to (-485, 450),
// selects symbol mode and restores char_advance to 13 and line_step to 28.
// ----------------------------------------------------------------------------
// vector_terminal_command_decoder: byte stream to draw commands
// Decodes control codes, gathers argument bytes, tracks a saturating beam
// position and emits character, vector and clear commands.
// ----------------------------------------------------------------------------
module vector_terminal_command_decoder #(
    parameter int POS_WIDTH = 12
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [vtcd_pkg::CFG_W-1:0]            i_cfg_data,
    // command bytes
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [vtcd_pkg::CODE_W-1:0]           i_code,
    // draw commands
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [vtcd_pkg::KIND_W-1:0]           o_kind,
    output logic [vtcd_pkg::CODE_W-1:0]           o_glyph,
    output logic signed [vtcd_pkg::OUT_POS_W-1:0] o_from_x,
    output logic signed [vtcd_pkg::OUT_POS_W-1:0] o_from_y,
    output logic signed [vtcd_pkg::OUT_POS_W-1:0] o_to_x,
    output logic signed [vtcd_pkg::OUT_POS_W-1:0] o_to_y
);

    localparam int SW = POS_WIDTH + 2;
    localparam logic signed [SW-1:0] POS_MAX = SW'((1 << (POS_WIDTH - 1)) - 1);
    localparam logic signed [SW-1:0] POS_MIN = -POS_MAX - SW'(1);
    localparam logic signed [POS_WIDTH-1:0] HOME_X = POS_WIDTH'(vtcd_pkg::HOME_X_VAL);
    localparam logic signed [POS_WIDTH-1:0] HOME_Y = POS_WIDTH'(vtcd_pkg::HOME_Y_VAL);
    localparam logic signed [POS_WIDTH-1:0] CR_X   = POS_WIDTH'(vtcd_pkg::CR_X_VAL);

    function automatic logic signed [POS_WIDTH-1:0] clamp_pos(logic signed [SW-1:0] v);
        if (v > POS_MAX) return POS_WIDTH'(POS_MAX);
        if (v < POS_MIN) return POS_WIDTH'(POS_MIN);
        return POS_WIDTH'(v);
    endfunction

    // configuration registers
    logic [vtcd_pkg::CFG_W-1:0] r_adv;
    logic [vtcd_pkg::CFG_W-1:0] r_step;

    // input stage
    logic                  r_in_vld;
    vtcd_pkg::t_byte       r_in_code;

    // decoder state
    logic [1:0]                       r_mode,  n_mode;
    logic [vtcd_pkg::PEND_W-1:0]      r_pend,  n_pend;
    vtcd_pkg::t_byte                  r_args [vtcd_pkg::NUM_ARGS];
    vtcd_pkg::t_byte                  n_args [vtcd_pkg::NUM_ARGS];
    logic signed [POS_WIDTH-1:0]      r_bx, n_bx;
    logic signed [POS_WIDTH-1:0]      r_by, n_by;

    // output stage
    logic                  r_out_vld;
    vtcd_pkg::t_result     r_out, n_out;
    logic                  n_emit;

    logic                  w_proceed;

    // datapath temporaries
    logic [vtcd_pkg::PEND_W-1:0]          w_p1;
    logic signed [SW-1:0]                 w_base_x, w_base_y, w_dx, w_dy;
    logic signed [SW-1:0]                 w_sum_x, w_sum_y;
    logic signed [POS_WIDTH-1:0]          w_cx, w_cy;
    logic                                 w_upd_x, w_upd_y, w_home, w_cr, w_vec;
    logic signed [vtcd_pkg::LONG_W-1:0]   w_lx, w_ly;
    logic signed [vtcd_pkg::SHORT_W-1:0]  w_sx, w_sy;

    assign w_proceed  = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_proceed;

    always_comb begin
        w_p1 = (r_pend != '0) ? r_pend - 1'b1 : '0;
        n_args = r_args;
        if (r_pend != '0) begin
            n_args[w_p1[1:0]] = r_in_code;
        end

        w_lx = vtcd_pkg::long_coord(n_args[3], n_args[2]);
        w_ly = vtcd_pkg::long_coord(n_args[1], n_args[0]);
        w_sx = vtcd_pkg::short_coord(n_args[1]);
        w_sy = vtcd_pkg::short_coord(n_args[0]);

        n_mode   = r_mode;
        n_pend   = w_p1;
        w_base_x = SW'(r_bx);
        w_base_y = SW'(r_by);
        w_dx     = '0;
        w_dy     = '0;
        w_upd_x  = 1'b0;
        w_upd_y  = 1'b0;
        w_home   = 1'b0;
        w_cr     = 1'b0;
        w_vec    = 1'b0;
        n_emit   = 1'b0;
        n_out    = '0;

        unique case (r_in_code) inside
            vtcd_pkg::C_BEL, vtcd_pkg::C_FS: begin
                n_mode = vtcd_pkg::MODE_SYMBOL;
                n_pend = '0;
            end
            vtcd_pkg::C_BS: begin
                n_mode  = vtcd_pkg::MODE_SYMBOL;
                n_pend  = '0;
                w_dx    = -SW'(r_adv);
                w_upd_x = 1'b1;
            end
            vtcd_pkg::C_LF: begin
                n_mode  = vtcd_pkg::MODE_SYMBOL;
                n_pend  = '0;
                w_dy    = -SW'(r_step);
                w_upd_y = 1'b1;
            end
            vtcd_pkg::C_FF: begin
                n_mode     = vtcd_pkg::MODE_SYMBOL;
                n_pend     = '0;
                w_home     = 1'b1;
                n_emit     = 1'b1;
                n_out.kind = vtcd_pkg::KIND_CLEAR;
            end
            vtcd_pkg::C_CR: begin
                n_mode = vtcd_pkg::MODE_SYMBOL;
                n_pend = '0;
                w_cr   = 1'b1;
            end
            vtcd_pkg::C_GS: begin
                n_mode = vtcd_pkg::MODE_POINT;
                n_pend = vtcd_pkg::ARGS_LONG;
            end
            vtcd_pkg::C_RS: begin
                n_mode = vtcd_pkg::MODE_EXT;
                n_pend = vtcd_pkg::ARGS_LONG;
            end
            vtcd_pkg::C_US: begin
                n_mode = vtcd_pkg::MODE_SHORT;
                n_pend = vtcd_pkg::ARGS_SHORT;
            end
            default: begin
                // data byte: stored as an argument while gathering, acted on once none remain
                if (w_p1 == '0) begin
                    unique case (r_mode)
                        vtcd_pkg::MODE_SYMBOL: begin
                            n_emit      = 1'b1;
                            n_out.kind  = vtcd_pkg::KIND_CHAR;
                            n_out.glyph = r_in_code;
                            w_dx        = SW'(r_adv);
                            w_upd_x     = 1'b1;
                        end
                        vtcd_pkg::MODE_POINT: begin
                            n_pend   = vtcd_pkg::ARGS_LONG;
                            w_base_x = '0;
                            w_base_y = '0;
                            w_dx     = SW'(w_lx);
                            w_dy     = SW'(w_ly);
                            w_upd_x  = 1'b1;
                            w_upd_y  = 1'b1;
                        end
                        vtcd_pkg::MODE_EXT: begin
                            n_pend  = vtcd_pkg::ARGS_LONG;
                            w_dx    = SW'(w_lx);
                            w_dy    = SW'(w_ly);
                            w_upd_x = 1'b1;
                            w_upd_y = 1'b1;
                            w_vec   = 1'b1;
                            n_emit  = !n_args[2][vtcd_pkg::INVIS_BIT];
                        end
                        default: begin
                            n_pend  = vtcd_pkg::ARGS_SHORT;
                            w_dx    = SW'(w_sx);
                            w_dy    = SW'(w_sy);
                            w_upd_x = 1'b1;
                            w_upd_y = 1'b1;
                            w_vec   = 1'b1;
                            n_emit  = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        w_sum_x = w_base_x + w_dx;
        w_sum_y = w_base_y + w_dy;
        w_cx    = clamp_pos(w_sum_x);
        w_cy    = clamp_pos(w_sum_y);

        if (w_home) begin
            n_bx = HOME_X;
        end else if (w_cr) begin
            n_bx = CR_X;
        end else if (w_upd_x) begin
            n_bx = w_cx;
        end else begin
            n_bx = r_bx;
        end

        if (w_home) begin
            n_by = HOME_Y;
        end else if (w_upd_y) begin
            n_by = w_cy;
        end else begin
            n_by = r_by;
        end

        if (w_vec) begin
            n_out.kind = vtcd_pkg::KIND_VECTOR;
            n_out.to_x = vtcd_pkg::OUT_POS_W'(w_cx);
            n_out.to_y = vtcd_pkg::OUT_POS_W'(w_cy);
        end
        if (!w_home) begin
            n_out.from_x = vtcd_pkg::OUT_POS_W'(r_bx);
            n_out.from_y = vtcd_pkg::OUT_POS_W'(r_by);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adv  <= vtcd_pkg::CHAR_ADVANCE_RST;
            r_step <= vtcd_pkg::LINE_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vtcd_pkg::CFG_CHAR_ADVANCE: r_adv  <= i_cfg_data;
                vtcd_pkg::CFG_LINE_STEP:    r_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_code <= i_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= vtcd_pkg::MODE_SYMBOL;
            r_pend <= '0;
            r_args <= '{default: '0};
            r_bx   <= HOME_X;
            r_by   <= HOME_Y;
        end else if (w_proceed) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_args <= n_args;
            r_bx   <= n_bx;
            r_by   <= n_by;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_proceed) begin
            r_out_vld <= n_emit;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && n_emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_kind      = r_out.kind;
    assign o_glyph     = r_out.glyph;
    assign o_from_x    = r_out.from_x;
    assign o_from_y    = r_out.from_y;
    assign o_to_x      = r_out.to_x;
    assign o_to_y      = r_out.to_y;

`ifndef SYNTHESIS
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= vtcd_pkg::ARGS_LONG)
        else $error("pending argument count out of range");

    a_short_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == vtcd_pkg::MODE_SHORT |-> r_pend <= vtcd_pkg::ARGS_SHORT)
        else $error("short mode armed more than two arguments");

    a_home_ff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proceed && r_in_code == vtcd_pkg::C_FF
        |=> r_bx == HOME_X && r_by == HOME_Y && r_out_vld
            && r_out.kind == vtcd_pkg::KIND_CLEAR)
        else $error("form feed did not home the beam and clear");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_vld && r_out_vld && i_out_stall)
        else $error("input stalled without a blocked result");

    a_glyph_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.kind != vtcd_pkg::KIND_CHAR |-> r_out.glyph == '0)
        else $error("glyph set on a non-character result");
`endif

endmodule
